// ===== rtl/dtst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dtst_pkg;

  localparam int QUEUE_SLOTS  = 16;
  localparam int PAYLOAD_BITS = 64;

  localparam int SLOT_W  = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int CNT_W   = $clog2(QUEUE_SLOTS + 1);
  localparam int HASH_W  = 64;
  localparam int OWNER_W = 8;
  localparam int LEASE_W = 48;
  localparam int ATT_W   = 4;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_CLAIM   = 2'd1,
    OP_FINISH  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    STATUS_OK          = 3'd0,
    STATUS_ZERO_HASH   = 3'd1,
    STATUS_PRESENT     = 3'd2,
    STATUS_DUPLICATE   = 3'd3,
    STATUS_FULL        = 3'd4,
    STATUS_NONE_PENDING = 3'd5,
    STATUS_BAD_SLOT    = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    SLOT_EMPTY   = 2'd0,
    SLOT_PENDING = 2'd1,
    SLOT_RUNNING = 2'd2
  } slot_st_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_CLAIM_RD,
    FSM_CLAIM_WB
  } fsm_t;

  // Per-slot bookkeeping written by enqueue and claim.
  typedef struct packed {
    logic [OWNER_W-1:0] owner;
    logic [LEASE_W-1:0] lease;
    logic [ATT_W-1:0]   attempts;
  } rec_t;

endpackage

`default_nettype wire

// ===== rtl/dedup_task_slot_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

// An enqueue with a nonzero, absent hash scans the hash memory (one slot read per cycle); a claim
// that finds a pending task passes through the claim read and write-back states; every other
// request strobes done in the cycle after it is accepted. One request is in flight at a time;
// busy drops with the strobe, so the next request may be accepted in the strobe cycle.
// The receiver cannot stall: done is high for a single cycle; result ports hold until the next result.
// Reset empties every slot and zeroes both counters; slot memories are not cleared.
module dedup_task_slot_table (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           op,
  input  wire logic [63:0]          entry_hash,
  input  wire logic [63:0]          entry_payload,
  input  wire logic                 summary_present,
  input  wire logic [7:0]           owner_id,
  input  wire logic [47:0]          now_time,
  input  wire logic [7:0]           target_slot,
  input  wire logic                 build_succeeded,
  output logic                      done,
  output logic [2:0]                status,
  output logic [3:0]                granted_slot,
  output logic [63:0]               granted_hash,
  output logic [63:0]               granted_payload,
  output logic [63:0]               enqueued_total,
  output logic [63:0]               built_total
);
  import dtst_pkg::*;

  fsm_t fsm, fsm_next;

  slot_st_t slot_state [QUEUE_SLOTS];

  logic [HASH_W-1:0]       hash_mem    [QUEUE_SLOTS];
  logic [PAYLOAD_BITS-1:0] payload_mem [QUEUE_SLOTS];
  rec_t                    rec_mem     [QUEUE_SLOTS];
  logic [HASH_W-1:0]       hash_rd;
  logic [PAYLOAD_BITS-1:0] payload_rd;
  rec_t                    rec_rd;

  logic [CNT_W-1:0]        cnt;
  logic                    cmp_v;
  logic [SLOT_W-1:0]       cmp_idx;
  logic                    dup;
  logic [SLOT_W-1:0]       slot_q;
  logic [HASH_W-1:0]       hash_q;
  logic [PAYLOAD_BITS-1:0] payload_q;
  logic [OWNER_W-1:0]      owner_q;
  logic [LEASE_W-1:0]      lease_q;
  logic [63:0]             enqueue_counter;
  logic [63:0]             build_counter;

  logic              accept;
  logic              pend_found, empty_found;
  logic [SLOT_W-1:0] pend_idx, empty_idx;
  logic              hit;
  logic              bad_target;

  logic [SLOT_W-1:0]       rd_addr;
  logic [SLOT_W-1:0]       wr_addr;
  logic                    ent_we;
  logic                    rec_we;
  rec_t                    wr_rec;
  logic                    st_we;
  logic [SLOT_W-1:0]       st_idx;
  slot_st_t                st_val;
  logic                    enq_inc, build_inc;
  logic                    res_v;
  status_t                 res_status;
  logic [SLOT_W-1:0]       res_slot;
  logic [HASH_W-1:0]       res_hash;
  logic [PAYLOAD_BITS-1:0] res_pay;

  assign busy   = (fsm != FSM_IDLE);
  assign accept = start && !busy;
  assign bad_target = ({1'b0, target_slot} >= 9'(QUEUE_SLOTS));

  // Lowest pending and lowest empty slot.
  always_comb begin
    pend_found  = 1'b0;
    pend_idx    = '0;
    empty_found = 1'b0;
    empty_idx   = '0;
    for (int i = QUEUE_SLOTS - 1; i >= 0; i--) begin
      if (slot_state[i] == SLOT_PENDING) begin
        pend_found = 1'b1;
        pend_idx   = SLOT_W'(i);
      end
      if (slot_state[i] == SLOT_EMPTY) begin
        empty_found = 1'b1;
        empty_idx   = SLOT_W'(i);
      end
    end
  end

  // Compare of the hash read in the previous scan cycle.
  assign hit = cmp_v && (slot_state[cmp_idx] != SLOT_EMPTY) && (hash_rd == hash_q);

  always_comb begin
    fsm_next = fsm;
    case (fsm)
      FSM_IDLE: begin
        if (accept && (op == OP_ENQUEUE) && (entry_hash != '0) && !summary_present) begin
          fsm_next = FSM_SCAN;
        end else if (accept && (op == OP_CLAIM) && pend_found) begin
          fsm_next = FSM_CLAIM_RD;
        end
      end
      FSM_SCAN: begin
        if (cnt == CNT_W'(QUEUE_SLOTS)) begin
          fsm_next = FSM_IDLE;
        end
      end
      FSM_CLAIM_RD: fsm_next = FSM_CLAIM_WB;
      FSM_CLAIM_WB: fsm_next = FSM_IDLE;
      default:      fsm_next = FSM_IDLE;
    endcase
  end

  always_comb begin
    rd_addr    = slot_q;
    wr_addr    = slot_q;
    ent_we     = 1'b0;
    rec_we     = 1'b0;
    wr_rec     = '0;
    st_we      = 1'b0;
    st_idx     = slot_q;
    st_val     = SLOT_EMPTY;
    enq_inc    = 1'b0;
    build_inc  = 1'b0;
    res_v      = 1'b0;
    res_status = STATUS_OK;
    res_slot   = '0;
    res_hash   = '0;
    res_pay    = '0;
    case (fsm)
      FSM_IDLE: begin
        if (accept) begin
          case (op)
            OP_ENQUEUE: begin
              if (entry_hash == '0) begin
                res_v      = 1'b1;
                res_status = STATUS_ZERO_HASH;
              end else if (summary_present) begin
                res_v      = 1'b1;
                res_status = STATUS_PRESENT;
              end
            end
            OP_CLAIM: begin
              if (!pend_found) begin
                res_v      = 1'b1;
                res_status = STATUS_NONE_PENDING;
              end
            end
            OP_FINISH: begin
              res_v = 1'b1;
              if (bad_target) begin
                res_status = STATUS_BAD_SLOT;
              end else begin
                // Clearing the state is enough: a later enqueue rewrites the whole entry.
                st_we     = 1'b1;
                st_idx    = target_slot[SLOT_W-1:0];
                st_val    = SLOT_EMPTY;
                build_inc = build_succeeded;
              end
            end
            default: begin
              res_v = 1'b1;
            end
          endcase
        end
      end
      FSM_SCAN: begin
        rd_addr = cnt[SLOT_W-1:0];
        if (cnt == CNT_W'(QUEUE_SLOTS)) begin
          res_v = 1'b1;
          if (dup || hit) begin
            res_status = STATUS_DUPLICATE;
          end else if (!empty_found) begin
            res_status = STATUS_FULL;
          end else begin
            wr_addr  = empty_idx;
            ent_we   = 1'b1;
            rec_we   = 1'b1;
            wr_rec   = '0;
            st_we    = 1'b1;
            st_idx   = empty_idx;
            st_val   = SLOT_PENDING;
            enq_inc  = 1'b1;
            res_slot = empty_idx;
          end
        end
      end
      FSM_CLAIM_RD: begin
        rd_addr = slot_q;
      end
      FSM_CLAIM_WB: begin
        rec_we          = 1'b1;
        wr_rec.owner    = owner_q;
        wr_rec.lease    = lease_q;
        wr_rec.attempts = rec_rd.attempts + ATT_W'(1);
        st_we           = 1'b1;
        st_val          = SLOT_RUNNING;
        res_v           = 1'b1;
        res_slot        = slot_q;
        res_hash        = hash_rd;
        res_pay         = payload_rd;
      end
      default: begin
        res_v = 1'b0;
      end
    endcase
  end

  // Slot memories: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (ent_we) begin
      hash_mem[wr_addr]    <= hash_q;
      payload_mem[wr_addr] <= payload_q;
    end
    hash_rd    <= hash_mem[rd_addr];
    payload_rd <= payload_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[wr_addr] <= wr_rec;
    end
    rec_rd <= rec_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm             <= FSM_IDLE;
      done            <= 1'b0;
      cmp_v           <= 1'b0;
      dup             <= 1'b0;
      cnt             <= '0;
      enqueue_counter <= '0;
      build_counter   <= '0;
      for (int i = 0; i < QUEUE_SLOTS; i++) begin
        slot_state[i] <= SLOT_EMPTY;
      end
    end else begin
      fsm  <= fsm_next;
      done <= res_v;
      if (st_we) begin
        slot_state[st_idx] <= st_val;
      end
      if (enq_inc) begin
        enqueue_counter <= enqueue_counter + 64'd1;
      end
      if (build_inc) begin
        build_counter <= build_counter + 64'd1;
      end
      if (fsm == FSM_IDLE) begin
        cnt   <= '0;
        cmp_v <= 1'b0;
        dup   <= 1'b0;
      end else if (fsm == FSM_SCAN) begin
        cnt     <= cnt + CNT_W'(1);
        cmp_v   <= (cnt < CNT_W'(QUEUE_SLOTS));
        cmp_idx <= cnt[SLOT_W-1:0];
        if (hit) begin
          dup <= 1'b1;
        end
      end
    end
  end

  // Request fields held for the multi-cycle operations.
  always_ff @(posedge clk) begin
    if (accept) begin
      hash_q    <= entry_hash;
      payload_q <= entry_payload[PAYLOAD_BITS-1:0];
      owner_q   <= owner_id;
      lease_q   <= now_time;
      slot_q    <= pend_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (res_v) begin
      status          <= res_status;
      granted_slot    <= 4'(res_slot);
      granted_hash    <= res_hash;
      granted_payload <= 64'(res_pay);
    end
  end

  assign enqueued_total = enqueue_counter;
  assign built_total    = build_counter;

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while a request is still in flight");

  a_zero_hash: assert property (@(posedge clk) disable iff (rst)
    (accept && (op == OP_ENQUEUE) && (entry_hash == '0))
      |=> (done && (status == STATUS_ZERO_HASH)))
    else $error("zero-hash enqueue not refused in the next cycle");

  a_enq_count: assert property (@(posedge clk) disable iff (rst)
    !$stable(enqueue_counter) |-> (done && (status == STATUS_OK)))
    else $error("enqueue count moved without a successful enqueue transfer");

  a_claim_pending: assert property (@(posedge clk) disable iff (rst)
    (fsm == FSM_CLAIM_WB) |-> (slot_state[slot_q] == SLOT_PENDING))
    else $error("claim write-back to a slot that is not pending");
`endif

endmodule

`default_nettype wire
